/* sv/mpeg_pkg.sv */
// Package with shared types and constants of the envelope generator.
`timescale 1ns / 1ps
package mpeg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_WRITE   = 2'd2,
    REQ_START   = 2'd3
  } req_t;

  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_SUSTAIN     = 2'd1;
  localparam logic [1:0] REG_FORCED      = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  point_index;
    logic [23:0] point_level;
    logic [16:0] point_step;
    logic [16:0] release_step;
  } req_item_t;

  typedef struct packed {
    logic [23:0] env_value;
    logic        env_finished;
  } res_item_t;

  // Back-end execution states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_MUL   = 2'd2,
    ST_OUT   = 2'd3
  } exec_state_t;

endpackage

/* sv/mpeg_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface mpeg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  point_index;
  logic [23:0] point_level;
  logic [16:0] point_step;
  logic [16:0] release_step;
  modport source(output valid, req_type, point_index, point_level, point_step, release_step,
    input ready);
  modport sink(input valid, req_type, point_index, point_level, point_step, release_step,
    output ready);
endinterface

interface mpeg_res_if;
  logic        valid;
  logic        ready;
  logic [23:0] env_value;
  logic        env_finished;
  modport source(output valid, env_value, env_finished, input ready);
  modport sink(input valid, env_value, env_finished, output ready);
endinterface

/* sv/mpeg_front.sv */
// Front end: accepts requests and queues them for the back end.
`timescale 1ns / 1ps
module mpeg_front #(
  parameter int Depth = 4
) (
  input  logic               clk,
  input  logic               rst,
  mpeg_req_if.sink           req,
  output mpeg_pkg::req_item_t q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  mpeg_pkg::req_item_t mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;

  assign req.ready = (count != (AW+1)'(Depth));
  assign push = req.valid && req.ready;
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{req.req_type, req.point_index, req.point_level,
                       req.point_step, req.release_step};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule

/* sv/mpeg_back.sv */
// Back end: point tables, envelope state and interpolation.
`timescale 1ns / 1ps
module mpeg_back (
  input  logic                clk,
  input  logic                rst,
  input  mpeg_pkg::req_item_t q_item,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [6:0]          point_count,
  input  logic [5:0]          sustain_point,
  input  logic                forced_release_enable,
  mpeg_res_if.source          res
);
  localparam logic [16:0] One = 17'h10000;

  logic [23:0] lvl_mem [64];
  logic [16:0] stp_mem [64];
  logic [16:0] rel_mem [64];

  mpeg_pkg::exec_state_t state, state_next;

  logic [6:0]  current_point;
  logic [17:0] phase;
  logic        key_released;
  logic        forced_pending;
  logic        finished;
  logic [23:0] held_value;

  // Tick operands: kind and indexes latched in ST_IDLE, table values in ST_READ.
  typedef enum logic [1:0] { K_FIN, K_SUS, K_FORCE, K_NORM } kind_t;
  kind_t       kind;
  logic [5:0]  idx_a, idx_b;
  logic [23:0] lvl_a, lvl_b;
  logic [16:0] stp_b, rel_b;
  logic signed [25:0] diff;
  logic signed [43:0] prod;
  logic [6:0]  npts;
  logic        out_valid;
  logic [23:0] out_value;
  logic        out_fin;

  always_comb begin
    npts = point_count;
    if (npts < 7'd2) npts = 7'd2;
    if (npts > 7'd64) npts = 7'd64;
  end

  function automatic logic [5:0] clampi(input logic [7:0] i);
    return (i >= 8'd64) ? 6'd63 : i[5:0];
  endfunction

  logic is_tick;
  assign is_tick = (mpeg_pkg::req_t'(q_item.req_type) == mpeg_pkg::REQ_TICK);
  // Non-tick requests finish in IDLE; a tick needs the output slot to be empty
  // or emptying in this cycle.
  assign q_pop = (state == mpeg_pkg::ST_IDLE) && q_valid &&
                 (!is_tick || !out_valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      mpeg_pkg::ST_IDLE: if (q_pop && is_tick) state_next = mpeg_pkg::ST_READ;
      mpeg_pkg::ST_READ: state_next = mpeg_pkg::ST_MUL;
      mpeg_pkg::ST_MUL:  state_next = mpeg_pkg::ST_OUT;
      mpeg_pkg::ST_OUT:  state_next = mpeg_pkg::ST_IDLE;
      default:           state_next = mpeg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && mpeg_pkg::req_t'(q_item.req_type) == mpeg_pkg::REQ_WRITE) begin
      lvl_mem[q_item.point_index] <= q_item.point_level;
      stp_mem[q_item.point_index] <= q_item.point_step;
      rel_mem[q_item.point_index] <= q_item.release_step;
    end
    if (state == mpeg_pkg::ST_READ) begin
      lvl_a <= lvl_mem[idx_a];
      lvl_b <= lvl_mem[idx_b];
      stp_b <= stp_mem[idx_b];
      rel_b <= rel_mem[idx_b];
    end
  end

  // Classify the tick and pick table indexes.
  always_ff @(posedge clk) begin
    if (q_pop && is_tick) begin
      if (finished) begin
        kind <= K_FIN; idx_b <= 6'(npts - 7'd1); idx_a <= 6'(npts - 7'd1);
      end else if (sustain_point != 0 && current_point == {1'b0, sustain_point} + 7'd1
                   && !key_released) begin
        kind <= K_SUS; idx_b <= sustain_point; idx_a <= sustain_point;
      end else if (key_released && forced_pending) begin
        kind <= K_FORCE;
        idx_b <= clampi((sustain_point == 0) ? {1'b0, npts - 7'd1}
                        : {2'b0, sustain_point} + 8'd1);
        idx_a <= 6'd0;
      end else begin
        kind <= K_NORM;
        idx_b <= clampi({1'b0, current_point});
        idx_a <= clampi({1'b0, current_point - 7'd1});
      end
    end
  end

  logic signed [23:0] base;
  logic [17:0] ph_sum;
  logic [16:0] st_sel;
  assign base = (kind == K_FORCE) ? $signed(held_value) : $signed(lvl_a);
  assign st_sel = (kind == K_FORCE) ? rel_b : stp_b;
  assign ph_sum = phase + {1'b0, st_sel};

  always_ff @(posedge clk) begin
    if (state == mpeg_pkg::ST_MUL) begin
      diff <= 26'($signed(lvl_b)) - 26'(base);
    end
  end
  // Floor division by 2^16 is an arithmetic shift.
  assign prod = 44'(diff) * $signed({1'b0, phase[16:0]});

  logic [23:0] lerp_v;
  assign lerp_v = 24'(base + 24'(prod >>> 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpeg_pkg::ST_IDLE;
      current_point <= 7'd1;
      phase <= '0;
      key_released <= 1'b0;
      forced_pending <= 1'b1;
      finished <= 1'b0;
      held_value <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) out_valid <= 1'b0;
      if (q_pop) begin
        unique case (mpeg_pkg::req_t'(q_item.req_type))
          mpeg_pkg::REQ_RELEASE: if (!key_released) begin
            key_released <= 1'b1;
            if (forced_pending) phase <= '0;
          end
          mpeg_pkg::REQ_START: begin
            current_point <= 7'd1; phase <= '0; key_released <= 1'b0;
            finished <= 1'b0; held_value <= '0;
            forced_pending <= forced_release_enable;
          end
          default: ;
        endcase
      end
      if (state == mpeg_pkg::ST_OUT) begin
        out_valid <= 1'b1;
        case (kind)
          K_FIN, K_SUS: begin
            held_value <= lvl_b; out_value <= lvl_b; out_fin <= finished;
          end
          K_FORCE: begin
            out_value <= (rel_b == 0) ? lvl_b : lerp_v;
            out_fin <= finished;
            if (ph_sum >= {1'b0, One}) begin
              current_point <= (sustain_point == 0) ? 7'd1 : {1'b0, sustain_point} + 7'd2;
              forced_pending <= 1'b0;
              phase <= '0;
              if (sustain_point == 0 || {1'b0, sustain_point} + 7'd2 >= npts) begin
                finished <= 1'b1; out_fin <= 1'b1;
              end
            end else phase <= ph_sum;
          end
          default: begin
            out_value <= (stp_b >= One) ? lvl_b : lerp_v;
            held_value <= (stp_b >= One) ? lvl_b : lerp_v;
            out_fin <= finished;
            if (ph_sum >= {1'b0, One}) begin
              phase <= '0;
              if (current_point >= npts - 7'd1) begin
                finished <= 1'b1; out_fin <= 1'b1;
              end else current_point <= current_point + 7'd1;
            end else phase <= ph_sum;
          end
        endcase
      end
    end
  end

  assign res.valid = out_valid;
  assign res.env_value = out_value;
  assign res.env_finished = out_fin;
endmodule

/* sv/multi_point_envelope_generator_core.sv */
// Top level of the multi-point envelope generator.
//   channel | dir | payload
//   req     | in  | req_type, point_index, point_level, point_step, release_step
//   res     | out | env_value, env_finished
//   apb     | in  | point_count, sustain_point, forced_release_enable
// A tick goes through select (IDLE), table read, difference, then multiply and
// update; writes, releases and note starts complete in IDLE. A tick may start
// in the cycle the previous result transfers, but not before the back end is
// back in IDLE; a tick waits at the queue head while a result sits untaken.
// Requests queue in a QueueDepth-entry FIFO (four by default), so input keeps
// flowing until it fills. Reset is synchronous; tables are not cleared.
`timescale 1ns / 1ps
module multi_point_envelope_generator_core #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  mpeg_req_if.sink    req,
  mpeg_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [6:0] point_count;
  logic [5:0] sustain_point;
  logic       forced_release_enable;
  mpeg_pkg::req_item_t q_item;
  logic q_valid, q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 7'd4;
      sustain_point <= 6'd2;
      forced_release_enable <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        mpeg_pkg::REG_POINT_COUNT: point_count <= pwdata[6:0];
        mpeg_pkg::REG_SUSTAIN:     sustain_point <= pwdata[5:0];
        mpeg_pkg::REG_FORCED:      forced_release_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mpeg_pkg::REG_POINT_COUNT: prdata = {25'd0, point_count};
      mpeg_pkg::REG_SUSTAIN:     prdata = {26'd0, sustain_point};
      mpeg_pkg::REG_FORCED:      prdata = {31'd0, forced_release_enable};
      default:                   prdata = '0;
    endcase
  end

  mpeg_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .req, .q_item, .q_valid, .q_pop
  );

  mpeg_back u_back (
    .clk, .rst, .q_item, .q_valid, .q_pop, .point_count, .sustain_point,
    .forced_release_enable, .res
  );

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.env_value))
    else $error("result changed while stalled");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> u_back.state == mpeg_pkg::ST_IDLE)
    else $error("pop while a tick is in progress");
endmodule

/* tb/multi_point_envelope_generator_core_chk.sv */
// Checker that predicts envelope values from observed transfers and compares results.
`timescale 1ns / 1ps
module multi_point_envelope_generator_core_chk (
  input  logic        clk,
  input  logic        rst,
  mpeg_req_if         req,
  mpeg_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          ticks_checked
);

  localparam int NumPts = 64;
  localparam longint PhaseOne = 65536;

  logic signed [23:0] lvl_mem [NumPts];
  logic [16:0]        stp_mem [NumPts];
  logic [16:0]        rel_mem [NumPts];
  int                 cur_pt;
  longint             ph;
  bit                 released;
  bit                 forced_pend;
  bit                 done;
  longint             held;
  int                 cnt_cfg;
  int                 sus_cfg;
  bit                 forced_cfg;

  mpeg_pkg::res_item_t envelope_q[$];

  assign pending = envelope_q.size();

  function automatic int sat_idx(int i);
    return (i >= NumPts) ? NumPts - 1 : i;
  endfunction

  function automatic longint interp(longint a, longint b, longint p);
    longint d;
    d = (b - a) * p;
    return a + (d >>> 16);
  endfunction

  function automatic void restart_note();
    cur_pt = 1;
    ph = 0;
    released = 0;
    done = 0;
    held = 0;
    forced_pend = forced_cfg;
  endfunction

  // Advances the envelope by one tick and returns the level it outputs.
  function automatic longint envelope_tick();
    int n;
    int tgt;
    int cur;
    longint o;
    n = cnt_cfg < 2 ? 2 : (cnt_cfg > NumPts ? NumPts : cnt_cfg);
    if (done) begin
      held = lvl_mem[n-1];
      return held;
    end
    if (sus_cfg != 0 && cur_pt == sus_cfg + 1 && !released) begin
      held = lvl_mem[sat_idx(sus_cfg)];
      return held;
    end
    if (released && forced_pend) begin
      tgt = sat_idx(sus_cfg == 0 ? n - 1 : sus_cfg + 1);
      if (rel_mem[tgt] == 0) o = lvl_mem[tgt];
      else o = interp(held, lvl_mem[tgt], ph);
      ph += rel_mem[tgt];
      if (ph >= PhaseOne) begin
        cur_pt = (sus_cfg == 0) ? 1 : sus_cfg + 2;
        forced_pend = 0;
        ph = 0;
        if (cur_pt >= n || sus_cfg == 0) done = 1;
      end
      return o;
    end
    cur = sat_idx(cur_pt);
    if (stp_mem[cur] >= PhaseOne) o = lvl_mem[cur];
    else o = interp(lvl_mem[sat_idx(cur_pt - 1)], lvl_mem[cur], ph);
    ph += stp_mem[cur];
    if (ph >= PhaseOne) begin
      if (cur_pt >= n - 1) done = 1;
      else cur_pt++;
      ph = 0;
    end
    held = o;
    return o;
  endfunction

  always @(posedge clk) begin
    mpeg_pkg::res_item_t want;
    mpeg_pkg::res_item_t e;
    if (rst) begin
      cnt_cfg = 4;
      sus_cfg = 2;
      forced_cfg = 1;
      restart_note();
      envelope_q.delete();
      fail_count = 0;
      ticks_checked = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (envelope_q.size() == 0) begin
          $error("unexpected result transfer: env_value %h", res.env_value);
          fail_count++;
        end else begin
          want = envelope_q.pop_front();
          ticks_checked++;
          if (res.env_value !== want.env_value) begin
            $error("env_value expected %h actual %h", want.env_value, res.env_value);
            fail_count++;
          end
          if (res.env_finished !== want.env_finished) begin
            $error("env_finished expected %b actual %b", want.env_finished,
                   res.env_finished);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        case (mpeg_pkg::req_t'(req.req_type))
          mpeg_pkg::REQ_TICK: begin
            e.env_value = 24'(envelope_tick());
            e.env_finished = done;
            envelope_q.push_back(e);
          end
          mpeg_pkg::REQ_RELEASE: begin
            if (!released) begin
              released = 1;
              if (forced_pend) ph = 0;
            end
          end
          mpeg_pkg::REQ_WRITE: begin
            lvl_mem[req.point_index] = req.point_level;
            stp_mem[req.point_index] = req.point_step;
            rel_mem[req.point_index] = req.release_step;
          end
          default: restart_note();
        endcase
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mpeg_pkg::REG_POINT_COUNT: cnt_cfg = pwdata[6:0];
          mpeg_pkg::REG_SUSTAIN:     sus_cfg = pwdata[5:0];
          mpeg_pkg::REG_FORCED:      forced_cfg = pwdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/multi_point_envelope_generator_core_tb.sv */
// Testbench top: drives requests and register writes, and reports the verdict.
`timescale 1ns / 1ps
module multi_point_envelope_generator_core_tb;

  localparam int CycleLimit = 600000;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          ticks_checked;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 0;
  int          hold_left = 0;
  bit          hold_used = 0;
  int          items_sent = 0;
  int          cfg_writes = 0;

  mpeg_req_if req ();
  mpeg_res_if res ();

  multi_point_envelope_generator_core dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  multi_point_envelope_generator_core_chk checker_i (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
    .pending(pending), .ticks_checked(ticks_checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("multi_point_envelope_generator_core test failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the input queue fills up.
  always @(negedge clk) begin
    if (rst) begin
      res.ready = 0;
    end else if (hold_left > 0) begin
      res.ready = 0;
      hold_left = hold_left - 1;
    end else if (hold_request && !hold_used) begin
      hold_used = 1;
      hold_left = 300;
      res.ready = 0;
    end else begin
      res.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    req.valid = 0;
    req.req_type = mpeg_pkg::REQ_TICK;
    req.point_index = 0;
    req.point_level = 0;
    req.point_step = 0;
    req.release_step = 0;
  end

  task automatic send(input mpeg_pkg::req_t t, input logic [5:0] idx = 0,
                      input logic [23:0] lvl = 0, input logic [16:0] stp = 0,
                      input logic [16:0] rstp = 0);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid = 0;
      @(negedge clk);
    end
    req.valid = 1;
    req.req_type = t;
    req.point_index = idx;
    req.point_level = lvl;
    req.point_step = stp;
    req.release_step = rstp;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] r, input logic [31:0] v);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {r, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    cfg_writes++;
  endtask

  task automatic set_config(input int cnt, input int sus, input bit frc);
    drain();
    write_reg(mpeg_pkg::REG_POINT_COUNT, cnt);
    write_reg(mpeg_pkg::REG_SUSTAIN, sus);
    write_reg(mpeg_pkg::REG_FORCED, frc);
  endtask

  function automatic logic [16:0] pick_step();
    case ($urandom_range(9))
      0: return 17'd65536;
      1: return 17'h1FFFF;
      2: return 17'($urandom_range(65535, 20000));
      3: return 17'($urandom);
      4: return ($urandom_range(3) == 0) ? 17'd0 : 17'd1;
      default: return 17'($urandom_range(30000, 2000));
    endcase
  endfunction

  function automatic logic [23:0] pick_level();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic note_run(input int nticks, input int rticks);
    send(mpeg_pkg::REQ_START);
    repeat (nticks) send(mpeg_pkg::REQ_TICK);
    send(mpeg_pkg::REQ_RELEASE);
    if ($urandom_range(3) == 0) send(mpeg_pkg::REQ_RELEASE);
    repeat (rticks) send(mpeg_pkg::REQ_TICK);
  endtask

  initial begin
    int phase_sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Fill the whole table so no tick ever reads an unwritten point.
    for (int i = 0; i < 64; i++)
      send(mpeg_pkg::REQ_WRITE, 6'(i), pick_level(), 17'($urandom_range(65536, 4000)),
           17'($urandom_range(65536, 4000)));

    // Directed: level extremes, jump and zero steps, every request kind.
    send(mpeg_pkg::REQ_WRITE, 0, 24'h800000, 17'd0, 17'd0);
    send(mpeg_pkg::REQ_WRITE, 1, 24'h7FFFFF, 17'd16384, 17'd0);
    send(mpeg_pkg::REQ_WRITE, 2, 24'h800000, 17'd65536, 17'h1FFFF);
    send(mpeg_pkg::REQ_WRITE, 3, 24'h000001, 17'h1FFFF, 17'd0);
    send(mpeg_pkg::REQ_WRITE, 63, 24'h7FFFFF, 17'd65536, 17'd65536);
    note_run(8, 4);
    set_config(2, 0, 0);
    note_run(4, 2);
    set_config(64, 63, 1);
    note_run(3, 3);
    set_config(127, 1, 1);
    note_run(3, 3);
    set_config(0, 2, 1);
    note_run(3, 3);

    send_idle_pct = 24;
    recv_idle_pct = 75;
    while (items_sent < 1700) begin
      phase_sel = items_sent - 100;
      if (phase_sel > 600 && send_idle_pct == 24) begin
        send_idle_pct = 75;
        recv_idle_pct = 24;
      end
      if (phase_sel > 1200 && send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase_sel > 1300) hold_request = 1;
      case ($urandom_range(19))
        0: set_config($urandom_range(1) ? $urandom_range(8, 2) : $urandom_range(127),
                      $urandom_range(1) ? $urandom_range(4) : $urandom_range(63),
                      $urandom_range(1));
        1, 2: send(mpeg_pkg::REQ_WRITE, 6'($urandom), pick_level(), pick_step(),
                   pick_step());
        3: send(mpeg_pkg::req_t'($urandom_range(3)), 6'($urandom), 24'($urandom),
                17'($urandom), 17'($urandom));
        default: note_run($urandom_range(24, 1), $urandom_range(16, 1));
      endcase
    end

    drain();
    $display("Sent %0d requests and checked %0d envelope ticks across %0d register writes.",
             items_sent, ticks_checked, cfg_writes);
    if (fail_count == 0) begin
      $display("multi_point_envelope_generator_core test passed");
    end else begin
      $display("multi_point_envelope_generator_core test failed");
    end
    $finish;
  end

endmodule
